/* hw/rtl/lfr3_pkg.sv */
// Shared types and constants for the 3D Lorenzo fixed-point reconstruction block.
// No dependencies; used by lfr3_ebound, lfr3_lane and the top module under hw/rtl.
`default_nettype none
package lfr3_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EB,
    S_MUL,
    S_READ,
    S_FIN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    EB_IDLE,
    EB_POW,
    EB_THR_LO,
    EB_THR_HI
  } eb_state_t;

  localparam logic [2:0] REG_BASE      = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_RADIUS    = 3'd2;
  localparam logic [2:0] REG_PLANES    = 3'd3;
  localparam logic [2:0] REG_ROWS      = 3'd4;
  localparam logic [2:0] REG_ROW_LEN   = 3'd5;

  localparam logic [63:0] CAP64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

  localparam int NUM_NBR = 7;
  // Neighbors subtracted in the Lorenzo sum, bit n for neighbor n.
  localparam logic [6:0] NEG_MASK = 7'b0010110;

  typedef struct packed {
    logic load;
    logic unpred;
    logic clear;
    logic mul_en;
    logic rd_en;
    logic acc_en;
    logic acc_neg;
    logic fin_en;
    logic wr_en;
  } lane_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/lfr3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lfr3_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4161
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/lfr3_ebound.sv */
// Iterative error-bound unit: eb = threshold * base^k, saturating at 2^63-1.
// Depends on lfr3_pkg.
`default_nettype none
module lfr3_ebound (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [10:0] k,
  input  wire logic [15:0] base,
  input  wire logic [31:0] threshold,
  output logic             done,
  output logic [63:0]      eb
);
  lfr3_pkg::eb_state_t state, state_next;
  logic [63:0] pw;
  logic [10:0] cnt;
  logic [10:0] k_r;
  logic [63:0] plo;
  logic [78:0] pwb;
  logic [62:0] phi;
  logic [94:0] total;
  logic        pow_stop;

  assign pwb      = 79'(pw[62:0]) * 79'(base);
  assign phi      = 63'(threshold) * 63'(pw[62:32]);
  assign total    = {phi, 32'b0} + 95'(plo);
  assign pow_stop = (cnt == k_r) || (pw == '0) || (pw == lfr3_pkg::CAP64);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfr3_pkg::EB_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == lfr3_pkg::EB_THR_HI);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lfr3_pkg::EB_IDLE:   if (start) state_next = lfr3_pkg::EB_POW;
      lfr3_pkg::EB_POW:    if (pow_stop) state_next = lfr3_pkg::EB_THR_LO;
      lfr3_pkg::EB_THR_LO: state_next = lfr3_pkg::EB_THR_HI;
      lfr3_pkg::EB_THR_HI: state_next = lfr3_pkg::EB_IDLE;
      default:             state_next = lfr3_pkg::EB_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      lfr3_pkg::EB_IDLE: begin
        pw  <= 64'd1;
        cnt <= '0;
        // hold the exponent, the input word may change once accepted
        k_r <= k;
      end
      lfr3_pkg::EB_POW: begin
        if (!pow_stop) begin
          pw  <= (pwb > 79'(lfr3_pkg::CAP64)) ? lfr3_pkg::CAP64 : pwb[63:0];
          cnt <= cnt + 11'd1;
        end
      end
      lfr3_pkg::EB_THR_LO: plo <= 64'(threshold) * 64'(pw[31:0]);
      lfr3_pkg::EB_THR_HI: eb <= (total > 95'(lfr3_pkg::CAP64)) ? lfr3_pkg::CAP64 : total[63:0];
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/lfr3_lane.sv */
// One component lane: history RAM, neighbor accumulation, scaled residual, saturation.
// Depends on lfr3_pkg and lfr3_ram.
`default_nettype none
module lfr3_lane #(
  parameter int DEPTH = 4161
) (
  input  wire logic                       clk,
  input  wire lfr3_pkg::lane_ctrl_t       ctrl,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [15:0]                radius,
  input  wire logic [63:0]                eb,
  input  wire logic [15:0]                q,
  input  wire logic [63:0]                raw,
  output logic      [63:0]                result
);
  logic [15:0]        q_r;
  logic [63:0]        raw_r;
  logic               unpred_r;
  logic signed [81:0] acc;
  logic signed [81:0] prod;
  logic [63:0]        rd_data;
  logic signed [16:0] d;
  logic [15:0]        mag;
  logic [79:0]        pmag;
  logic signed [82:0] sum;

  assign d    = $signed({1'b0, q_r}) - $signed({1'b0, radius});
  assign mag  = d[16] ? 16'(-d) : d[15:0];
  assign pmag = 80'(eb[62:0]) * 80'({mag, 1'b0});
  assign sum  = {acc[81], acc} + {prod[81], prod};

  lfr3_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_hist (
    .clk   (clk),
    .we    (ctrl.wr_en),
    .waddr (wr_addr),
    .wdata (result),
    .re    (ctrl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q_r      <= q;
      raw_r    <= raw;
      unpred_r <= ctrl.unpred;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= ctrl.acc_neg ? acc - {{18{rd_data[63]}}, rd_data}
                          : acc + {{18{rd_data[63]}}, rd_data};
    end
    if (ctrl.mul_en) begin
      prod <= d[16] ? -$signed({2'b0, pmag}) : $signed({2'b0, pmag});
    end
    if (ctrl.fin_en) begin
      if (unpred_r) begin
        result <= raw_r;
      end else if (sum[82:63] == {20{1'b0}} || sum[82:63] == {20{1'b1}}) begin
        result <= sum[63:0];
      end else begin
        result <= sum[82] ? lfr3_pkg::MIN64 : lfr3_pkg::CAP64;
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/lorenzo_fixed_point_recon_3d_top.sv */
// Top level: config registers, grid counters, sequencer, component lanes, output register.
// Depends on lfr3_pkg, lfr3_ebound, lfr3_lane (and lfr3_ram through the lanes).
//
//  port group   dir  handshake          payload
//  cfg          in   cfg_we             cfg_index, cfg_data
//  in           in   in_valid/in_ready  eb_index, q_u/v/w, raw_u/v/w
//  out          out  out_valid/out_ready out_u/v/w, unpredictable, last_point
//
// Raw points skip the error-bound unit and the history reads. Predicted points first
// run the multiply steps of the power loop in the error-bound unit: k steps,
// ending early once the power hits zero or saturates (one step for base 0, at most
// 63 for base 2 and up, all k, up to 2047, for base 1); then up to seven history
// reads, one per cycle on each lane's RAM port. A result waits in the output register
// while the next word is accepted. Reset clears counters and config; the history RAM
// is not cleared.
`default_nettype none
module lorenzo_fixed_point_recon_3d_top #(
  parameter int MAX_ROW_LEN = 64,
  parameter int MAX_ROWS    = 64,
  parameter int COMPONENTS  = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [10:0]        eb_index,
  input  wire logic [15:0]        q_u,
  input  wire logic [15:0]        q_v,
  input  wire logic [15:0]        q_w,
  input  wire logic signed [63:0] raw_u,
  input  wire logic signed [63:0] raw_v,
  input  wire logic signed [63:0] raw_w,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      out_u,
  output logic signed [63:0]      out_v,
  output logic signed [63:0]      out_w,
  output logic                    unpredictable,
  output logic                    last_point
);
  localparam int HIST_DEPTH = MAX_ROWS * MAX_ROW_LEN + MAX_ROW_LEN + 1;
  localparam int AW  = $clog2(HIST_DEPTH);
  localparam int CLW = $clog2(MAX_ROW_LEN + 1);
  localparam int RLW = $clog2(MAX_ROWS + 1);
  localparam int CCW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int RCW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  lfr3_pkg::state_t     state, state_next;
  lfr3_pkg::lane_ctrl_t ctrl;

  logic [15:0] base, radius, num_planes;
  logic [31:0] threshold;
  logic [6:0]  rows_per_plane, row_length;

  logic [CCW-1:0] col_count;
  logic [RCW-1:0] row_count;
  logic [15:0]    plane_count;
  logic [AW-1:0]  wr_pos;
  logic [AW:0]    pl_q;
  logic [2:0]     nbr;
  logic           acc_pend, neg_pend, unpred_r;

  logic [CLW-1:0] cols;
  logic [RLW-1:0] rows;
  logic [15:0]    planes;
  logic           last_c, last_r, last_p, adv;
  logic [6:0]     nbr_use;
  logic [AW:0]    ofs;
  logic [AW+1:0]  tsum;
  logic [AW-1:0]  rd_addr;
  logic           eb_start, eb_done;
  logic [63:0]    eb;

  logic [15:0] q_in   [3];
  logic [63:0] raw_in [3];
  logic [63:0] res    [3];

  assign q_in[0] = q_u;  assign q_in[1] = q_v;  assign q_in[2] = q_w;
  assign raw_in[0] = raw_u;  assign raw_in[1] = raw_v;  assign raw_in[2] = raw_w;

  // Config
  always_ff @(posedge clk) begin
    if (rst) begin
      base           <= 16'd2;
      threshold      <= 32'd1;
      radius         <= 16'd32768;
      num_planes     <= 16'd1;
      rows_per_plane <= 7'd64;
      row_length     <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        lfr3_pkg::REG_BASE:      base           <= cfg_data[15:0];
        lfr3_pkg::REG_THRESHOLD: threshold      <= cfg_data;
        lfr3_pkg::REG_RADIUS:    radius         <= cfg_data[15:0];
        lfr3_pkg::REG_PLANES:    num_planes     <= cfg_data[15:0];
        lfr3_pkg::REG_ROWS:      rows_per_plane <= cfg_data[6:0];
        lfr3_pkg::REG_ROW_LEN:   row_length     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions
  assign cols   = (row_length == '0) ? CLW'(1) :
                  (32'(row_length) > MAX_ROW_LEN) ? CLW'(MAX_ROW_LEN) : CLW'(row_length);
  assign rows   = (rows_per_plane == '0) ? RLW'(1) :
                  (32'(rows_per_plane) > MAX_ROWS) ? RLW'(MAX_ROWS) : RLW'(rows_per_plane);
  assign planes = (num_planes == '0) ? 16'd1 : num_planes;
  assign last_c = (32'(col_count) + 32'd1) >= 32'(cols);
  assign last_r = (32'(row_count) + 32'd1) >= 32'(rows);
  assign last_p = (32'(plane_count) + 32'd1) >= 32'(planes);

  // Neighbor selection and ring address
  always_comb begin
    nbr_use[0] = (plane_count != '0) && (row_count != '0) && (col_count != '0);
    nbr_use[1] = (plane_count != '0) && (row_count != '0);
    nbr_use[2] = (plane_count != '0) && (col_count != '0);
    nbr_use[3] = (plane_count != '0);
    nbr_use[4] = (row_count != '0) && (col_count != '0);
    nbr_use[5] = (row_count != '0);
    nbr_use[6] = (col_count != '0);
    case (nbr)
      3'd0:    ofs = pl_q + (AW+1)'(cols) + (AW+1)'(1);
      3'd1:    ofs = pl_q + (AW+1)'(cols);
      3'd2:    ofs = pl_q + (AW+1)'(1);
      3'd3:    ofs = pl_q;
      3'd4:    ofs = (AW+1)'(cols) + (AW+1)'(1);
      3'd5:    ofs = (AW+1)'(cols);
      3'd6:    ofs = (AW+1)'(1);
      default: ofs = '0;
    endcase
    tsum    = (AW+2)'(wr_pos) + (AW+2)'(HIST_DEPTH) - (AW+2)'(ofs);
    rd_addr = (tsum >= (AW+2)'(HIST_DEPTH)) ? AW'(tsum - (AW+2)'(HIST_DEPTH)) : AW'(tsum);
  end

  lfr3_ebound u_eb (
    .clk       (clk),
    .rst       (rst),
    .start     (eb_start),
    .k         (eb_index),
    .base      (base),
    .threshold (threshold),
    .done      (eb_done),
    .eb        (eb)
  );

  for (genvar c = 0; c < 3; c++) begin : g_lane
    if (c < COMPONENTS) begin : g_on
      lfr3_lane #(.DEPTH(HIST_DEPTH)) u_lane (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd_addr (rd_addr),
        .wr_addr (wr_pos),
        .radius  (radius),
        .eb      (eb),
        .q       (q_in[c]),
        .raw     (raw_in[c]),
        .result  (res[c])
      );
    end else begin : g_off
      assign res[c] = '0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfr3_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctrl         = '0;
    ctrl.acc_en  = acc_pend;
    ctrl.acc_neg = neg_pend;
    ctrl.unpred  = (eb_index == '0);
    eb_start     = 1'b0;
    adv          = 1'b0;
    in_ready     = 1'b0;
    case (state)
      lfr3_pkg::S_IDLE: begin
        // take no word while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          ctrl.load  = 1'b1;
          ctrl.clear = 1'b1;
          if (eb_index == '0) begin
            state_next = lfr3_pkg::S_FIN;
          end else begin
            eb_start   = 1'b1;
            state_next = lfr3_pkg::S_EB;
          end
        end
      end
      lfr3_pkg::S_EB: if (eb_done) state_next = lfr3_pkg::S_MUL;
      lfr3_pkg::S_MUL: begin
        ctrl.mul_en = 1'b1;
        state_next  = lfr3_pkg::S_READ;
      end
      lfr3_pkg::S_READ: begin
        ctrl.rd_en = (nbr != 3'd7) && nbr_use[nbr];
        if (nbr == 3'd7) state_next = lfr3_pkg::S_FIN;
      end
      lfr3_pkg::S_FIN: begin
        ctrl.fin_en = 1'b1;
        state_next  = lfr3_pkg::S_OUT;
      end
      lfr3_pkg::S_OUT: begin
        // hold until the output register frees up
        if (!out_valid || out_ready) begin
          ctrl.wr_en = 1'b1;
          adv        = 1'b1;
          state_next = lfr3_pkg::S_IDLE;
        end
      end
      default: state_next = lfr3_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    pl_q <= (AW+1)'(32'(cols) * 32'(rows));
    if (in_valid && in_ready) unpred_r <= (eb_index == '0);
    if (rst) begin
      nbr      <= '0;
      acc_pend <= 1'b0;
      neg_pend <= 1'b0;
    end else begin
      nbr      <= (state == lfr3_pkg::S_READ) ? nbr + 3'd1 : 3'd0;
      acc_pend <= ctrl.rd_en;
      neg_pend <= (nbr != 3'd7) && lfr3_pkg::NEG_MASK[nbr];
    end
  end

  // Grid counters and ring write position
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      plane_count <= '0;
      wr_pos      <= '0;
    end else if (adv) begin
      wr_pos <= (32'(wr_pos) == HIST_DEPTH - 1) ? '0 : wr_pos + AW'(1);
      if (!last_c) begin
        col_count <= col_count + CCW'(1);
      end else begin
        col_count <= '0;
        if (!last_r) begin
          row_count <= row_count + RCW'(1);
        end else begin
          row_count   <= '0;
          plane_count <= last_p ? 16'd0 : plane_count + 16'd1;
        end
      end
    end
  end

  // Merge lane results into the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      out_u         <= res[0];
      out_v         <= res[1];
      out_w         <= res[2];
      unpredictable <= unpred_r;
      last_point    <= last_c && last_r && last_p;
    end
  end

  a_wr_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_en |-> (!out_valid || out_ready)) else $error("history write while output busy");
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("second word accepted mid-item");
  a_grid_wrap: assert property (@(posedge clk) disable iff (rst)
    (adv && last_c && last_r && last_p) |=>
      (col_count == '0 && row_count == '0 && plane_count == '0))
    else $error("counters not cleared at grid end");
  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_en |-> (32'(rd_addr) < HIST_DEPTH)) else $error("history read out of range");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid) else $error("result not presented");

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for lorenzo_fixed_point_recon_3d_top: random and directed grid points
// are checked against a built-in predictor of the 3D Lorenzo reconstruction.
// Depends on lfr3_pkg and the top module of the block.
`default_nettype none

typedef struct {
  logic [10:0]        eb;
  logic [15:0]        q   [3];
  logic signed [63:0] raw [3];
} grid_point_t;

typedef struct {
  logic signed [63:0] val [3];
  logic               unpred;
  logic               last;
} recon_t;

class recon_scoreboard;
  localparam int HIST_DEPTH = 64 * 64 + 64 + 1;

  logic signed [63:0] hist [3][HIST_DEPTH];
  int unsigned wr_pos, plane_cnt, row_cnt, col_cnt;
  logic [15:0] base, radius, planes;
  logic [31:0] threshold;
  logic [6:0]  rows, cols;
  recon_t      pending_q [$];
  int          errors, points, results, raw_points, grids;

  function new();
    foreach (hist[c, n]) hist[c][n] = '0;
    wr_pos = 0; plane_cnt = 0; row_cnt = 0; col_cnt = 0;
    base = 2; threshold = 1; radius = 16'd32768; planes = 1; rows = 64; cols = 64;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      lfr3_pkg::REG_BASE:      base = d[15:0];
      lfr3_pkg::REG_THRESHOLD: threshold = d;
      lfr3_pkg::REG_RADIUS:    radius = d[15:0];
      lfr3_pkg::REG_PLANES:    planes = d[15:0];
      lfr3_pkg::REG_ROWS:      rows = d[6:0];
      lfr3_pkg::REG_ROW_LEN:   cols = d[6:0];
      default: ;
    endcase
  endfunction

  function bit at_grid_start();
    return plane_cnt == 0 && row_cnt == 0 && col_cnt == 0;
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  // Saturating threshold * base^k.
  function logic [63:0] error_bound(int unsigned k);
    logic [127:0] t;
    logic [63:0]  pw;
    pw = 1;
    for (int unsigned n = 0; n < k; n++) begin
      t = pw * base;
      pw = (t > lfr3_pkg::CAP64) ? lfr3_pkg::CAP64 : t[63:0];
      if (pw == 0 || pw == lfr3_pkg::CAP64) break;
    end
    t = threshold * pw;
    return (t > lfr3_pkg::CAP64) ? lfr3_pkg::CAP64 : t[63:0];
  endfunction

  function void note_point(grid_point_t p);
    int unsigned nc, nr, np, pl;
    int unsigned offs [7];
    bit          used [7];
    bit          neg  [7];
    bit          lc, lr, lp;
    logic [63:0] eb;
    logic signed [127:0] acc, dd, ebw, hi_lim, lo_lim;
    int          d;
    recon_t      r;
    nc = (cols == 0) ? 1 : (cols > 64) ? 64 : cols;
    nr = (rows == 0) ? 1 : (rows > 64) ? 64 : rows;
    np = (planes == 0) ? 1 : planes;
    pl = nc * nr;
    r.unpred = (p.eb == 0);
    if (r.unpred) begin
      for (int c = 0; c < 3; c++) r.val[c] = p.raw[c];
      raw_points++;
    end else begin
      eb = error_bound(p.eb);
      offs = '{pl + nc + 1, pl + nc, pl + 1, pl, nc + 1, nc, 1};
      neg  = '{0, 1, 1, 0, 1, 0, 0};
      used[0] = plane_cnt != 0 && row_cnt != 0 && col_cnt != 0;
      used[1] = plane_cnt != 0 && row_cnt != 0;
      used[2] = plane_cnt != 0 && col_cnt != 0;
      used[3] = plane_cnt != 0;
      used[4] = row_cnt != 0 && col_cnt != 0;
      used[5] = row_cnt != 0;
      used[6] = col_cnt != 0;
      hi_lim = $signed({64'b0, lfr3_pkg::CAP64});
      lo_lim = $signed({{64{1'b1}}, lfr3_pkg::MIN64});
      ebw = $signed({64'b0, eb});
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int n = 0; n < 7; n++) begin
          if (used[n]) begin
            dd = hist[c][(wr_pos + HIST_DEPTH - offs[n]) % HIST_DEPTH];
            acc = neg[n] ? acc - dd : acc + dd;
          end
        end
        d = int'(p.q[c]) - int'(radius);
        dd = 2 * d;
        acc = acc + dd * ebw;
        if (acc > hi_lim) r.val[c] = lfr3_pkg::CAP64;
        else if (acc < lo_lim) r.val[c] = lfr3_pkg::MIN64;
        else r.val[c] = acc[63:0];
      end
    end
    for (int c = 0; c < 3; c++) hist[c][wr_pos] = r.val[c];
    wr_pos = (wr_pos + 1) % HIST_DEPTH;
    lc = col_cnt + 1 >= nc;
    lr = row_cnt + 1 >= nr;
    lp = plane_cnt + 1 >= np;
    if (!lc) col_cnt++;
    else begin
      col_cnt = 0;
      if (!lr) row_cnt++;
      else begin
        row_cnt = 0;
        plane_cnt = lp ? 0 : plane_cnt + 1;
      end
    end
    r.last = lc && lr && lp;
    if (r.last) grids++;
    points++;
    pending_q.insert(pending_q.size(), r);
  endfunction

  function void check_result(recon_t a);
    recon_t e;
    if (pending_q.size() == 0) begin
      $error("result word with no point outstanding: u=%0d v=%0d w=%0d",
             a.val[0], a.val[1], a.val[2]);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    results++;
    if (a.val[0] !== e.val[0]) begin
      $error("out_u expected %0d got %0d", e.val[0], a.val[0]); errors++;
    end
    if (a.val[1] !== e.val[1]) begin
      $error("out_v expected %0d got %0d", e.val[1], a.val[1]); errors++;
    end
    if (a.val[2] !== e.val[2]) begin
      $error("out_w expected %0d got %0d", e.val[2], a.val[2]); errors++;
    end
    if (a.unpred !== e.unpred) begin
      $error("unpredictable expected %0b got %0b", e.unpred, a.unpred); errors++;
    end
    if (a.last !== e.last) begin
      $error("last_point expected %0b got %0b", e.last, a.last); errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [10:0] eb_index = '0;
  logic [15:0] q_u = '0, q_v = '0, q_w = '0;
  logic signed [63:0] raw_u = '0, raw_v = '0, raw_w = '0;
  logic out_valid, out_ready = 0;
  logic signed [63:0] out_u, out_v, out_w;
  logic unpredictable, last_point;

  recon_scoreboard sb = new();
  int burst_left = 0;
  bit gaps_on = 1;
  int ready_mode = 0;
  int raw_pct = 25;
  int unsigned cyc = 0;

  lorenzo_fixed_point_recon_3d_top dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .eb_index, .q_u, .q_v, .q_w, .raw_u, .raw_v, .raw_w,
    .out_valid, .out_ready, .out_u, .out_v, .out_w, .unpredictable, .last_point
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    cyc <= cyc + 1;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(99) < 55);
      default: out_ready <= (cyc % 11) < 4;
    endcase
  end

  always @(posedge clk) begin
    recon_t a;
    if (!rst && out_valid && out_ready) begin
      a.val[0] = out_u; a.val[1] = out_v; a.val[2] = out_w;
      a.unpred = unpredictable; a.last = last_point;
      sb.check_result(a);
    end
  end

  function automatic logic signed [63:0] rand_raw();
    case ($urandom_range(9))
      0: return lfr3_pkg::CAP64;
      1: return lfr3_pkg::MIN64;
      2: return $signed(64'($urandom_range(2000))) - 1000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic grid_point_t make_point();
    grid_point_t p;
    if ($urandom_range(99) < raw_pct) p.eb = 0;
    else if ($urandom_range(9) == 0) p.eb = $urandom_range(2047);
    else p.eb = $urandom_range(1, 40);
    for (int c = 0; c < 3; c++) begin
      if ($urandom_range(3) == 0) p.q[c] = $urandom;
      else p.q[c] = sb.radius + $urandom_range(64) - 32;
      p.raw[c] = rand_raw();
    end
    return p;
  endfunction

  task automatic send_point(grid_point_t p);
    if (gaps_on && burst_left == 0) begin
      @(negedge clk) in_valid = 0;
      repeat ($urandom_range(8)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end else begin
      @(negedge clk);
    end
    in_valid = 1;
    eb_index = p.eb;
    q_u = p.q[0]; q_v = p.q[1]; q_w = p.q[2];
    raw_u = p.raw[0]; raw_v = p.raw[1]; raw_w = p.raw[2];
    do @(posedge clk); while (!in_ready);
    sb.note_point(p);
    if (burst_left > 0) burst_left--;
  endtask

  // Hold off the sender until every outstanding word has come back.
  task automatic drain();
    @(negedge clk) in_valid = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = d;
    sb.write_reg(idx, d);
    @(negedge clk) cfg_we = 0;
  endtask

  task automatic finish_grid();
    while (!sb.at_grid_start()) send_point(make_point());
  endtask

  task automatic run_phase(logic [31:0] b, logic [31:0] thr, logic [31:0] rad,
                           logic [31:0] np, logic [31:0] nr, logic [31:0] nc, int n);
    drain();
    cfg_write(lfr3_pkg::REG_BASE, b);
    cfg_write(lfr3_pkg::REG_THRESHOLD, thr);
    cfg_write(lfr3_pkg::REG_RADIUS, rad);
    cfg_write(lfr3_pkg::REG_PLANES, np);
    cfg_write(lfr3_pkg::REG_ROWS, nr);
    cfg_write(lfr3_pkg::REG_ROW_LEN, nc);
    gaps_on = $urandom_range(3) != 0;
    ready_mode = $urandom_range(2);
    repeat (n) send_point(make_point());
    finish_grid();
  endtask

  task automatic directed_point(logic [10:0] e, logic [15:0] qa, logic [15:0] qb,
                                logic [15:0] qc, logic signed [63:0] ra,
                                logic signed [63:0] rb, logic signed [63:0] rc);
    grid_point_t p;
    p.eb = e; p.q = '{qa, qb, qc}; p.raw = '{ra, rb, rc};
    send_point(p);
  endtask

  initial begin
    #300_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned nr, nc;
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 0;

    // Directed: 3x3x2 grid under the reset ladder.
    run_phase(2, 1, 32768, 2, 3, 3, 0);
    directed_point(0, 0, 0, 0, lfr3_pkg::CAP64, lfr3_pkg::CAP64, lfr3_pkg::CAP64);
    directed_point(0, 16'hFFFF, 0, 0, lfr3_pkg::MIN64, lfr3_pkg::MIN64, lfr3_pkg::MIN64);
    directed_point(0, 0, 0, 0, 0, -1, 1);
    directed_point(1, 32768, 32768, 32768, 0, 0, 0);
    directed_point(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0);
    directed_point(11'h7FF, 0, 0, 0, 0, 0, 0);
    directed_point(1, 0, 16'hFFFF, 32768, 0, 0, 0);
    directed_point(11'h7FF, 32768, 32767, 32769, 0, 0, 0);
    directed_point(62, 32769, 32767, 32770, 0, 0, 0);
    directed_point(63, 32767, 32769, 32768, 0, 0, 0);
    directed_point(0, 1, 2, 3, 64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA, 7);
    for (int n = 0; n < 7; n++) directed_point(n + 1, 32768 + n, 32768 - n, 40000, 0, 0, 0);

    // Register extremes and clamped dimensions.
    run_phase(2, 1, 32768, 1, 8, 8, 100);
    run_phase(0, 7, 100, 2, 5, 4, 80);
    run_phase(1, 32'hFFFF_FFFF, 1, 3, 2, 3, 60);
    run_phase(65535, 0, 32768, 1, 1, 1, 40);
    run_phase(3, 1000, 0, 0, 0, 0, 40);
    run_phase(65535, 32'hFFFF_FFFF, 65535, 2, 127, 2, 100);
    run_phase(7, 12345, 32768, 1, 3, 127, 100);

    // Huge plane count, then shrink it mid-grid.
    run_phase(2, 3, 32768, 65535, 2, 2, 0);
    repeat (90) send_point(make_point());
    drain();
    cfg_write(lfr3_pkg::REG_PLANES, 1);
    finish_grid();

    repeat (5)
      run_phase($urandom_range(65535), $urandom, $urandom_range(65535),
                $urandom_range(3), $urandom_range(10), $urandom_range(10),
                $urandom_range(20, 60));

    // Mostly raw 16x16 plane, then shrink the plane twice mid-grid.
    raw_pct = 85;
    run_phase(2, 5, 32768, 1, 16, 16, 0);
    repeat (150) send_point(make_point());
    raw_pct = 25;
    nr = $urandom_range(1, 12);
    nc = $urandom_range(1, 12);
    repeat (2) begin
      drain();
      cfg_write(lfr3_pkg::REG_ROWS, nr);
      cfg_write(lfr3_pkg::REG_ROW_LEN, nc);
      cfg_write(lfr3_pkg::REG_PLANES, $urandom_range(2));
      ready_mode = $urandom_range(2);
      repeat (60) send_point(make_point());
      nr = $urandom_range(1, nr);
      nc = $urandom_range(1, nc);
    end
    finish_grid();

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d points (%0d raw), %0d results, %0d complete grids.",
             sb.points, sb.raw_points, sb.results, sb.grids);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/lfr3_pkg.sv
hw/rtl/lfr3_ram.sv
hw/rtl/lfr3_ebound.sv
hw/rtl/lfr3_lane.sv
hw/rtl/lorenzo_fixed_point_recon_3d_top.sv
sim/testbench.sv
